// ----- src/yrc_pkg.sv -----
// Shared types and constants for the 4:2:2 to RGB converter with crop window.
`timescale 1ns / 1ps
package yrc_pkg;

    localparam int PIX_WIDTH_CAP_DEF  = 4096;
    localparam int PIX_HEIGHT_CAP_DEF = 4096;

    // Wide enough for every window bound and position compare at any legal size
    localparam int CMP_W = 15;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 13;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CAM_WIDTH    = 3'd0,
        REG_CAM_HEIGHT   = 3'd1,
        REG_CROP_ENABLE  = 3'd2,
        REG_X_OFF        = 3'd3,
        REG_Y_OFF        = 3'd4,
        REG_WIN_WIDTH    = 3'd5,
        REG_WIN_HEIGHT   = 3'd6,
        REG_BYTE_ORDER   = 3'd7
    } cfg_reg_t;

    localparam int PROD_W = 18;
    localparam int SUM_W  = 20;

    localparam int OUT_DEPTH = 4;
    localparam int OUT_PTR_W = 2;
    localparam int OUT_CNT_W = 3;

    typedef struct packed {
        logic emit;
        logic row_end;
        logic frame_end;
    } pos_info_t;

    typedef struct packed {
        logic byte_order;
        logic busy;
    } pos_ctl_t;

    typedef struct packed {
        logic signed [PROD_W-1:0] red_v;
        logic signed [PROD_W-1:0] green_uv;
        logic signed [PROD_W-1:0] blue_u;
    } chroma_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } rgb_t;

    typedef struct packed {
        logic [7:0] luma_first;
        logic [7:0] luma_second;
        rgb_t       first;
        rgb_t       second;
        logic       row_end;
        logic       frame_end;
    } result_t;

endpackage

// ----- src/yrc_pix_if.sv -----
// Macropixel input channel.
`timescale 1ns / 1ps
interface yrc_pix_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_zero;
    logic [7:0] byte_one;
    logic [7:0] byte_two;
    logic [7:0] byte_three;
    logic       start_of_frame;

    modport source (
        output valid, byte_zero, byte_one, byte_two, byte_three, start_of_frame,
        input  ready
    );
    modport sink (
        input  valid, byte_zero, byte_one, byte_two, byte_three, start_of_frame,
        output ready
    );
endinterface

// ----- src/yrc_res_if.sv -----
// Converted pixel pair output channel.
`timescale 1ns / 1ps
interface yrc_res_if;
    logic       valid;
    logic       ready;
    logic [7:0] luma_first;
    logic [7:0] luma_second;
    logic [7:0] red_first;
    logic [7:0] green_first;
    logic [7:0] blue_first;
    logic [7:0] red_second;
    logic [7:0] green_second;
    logic [7:0] blue_second;
    logic       row_end;
    logic       frame_end;

    modport source (
        output valid, luma_first, luma_second, red_first, green_first, blue_first,
               red_second, green_second, blue_second, row_end, frame_end,
        input  ready
    );
    modport sink (
        input  valid, luma_first, luma_second, red_first, green_first, blue_first,
               red_second, green_second, blue_second, row_end, frame_end,
        output ready
    );
endinterface

// ----- src/yrc_cfg_if.sv -----
// Register write channel.
`timescale 1ns / 1ps
interface yrc_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [yrc_pkg::CFG_IDX_W-1:0]  index;
    logic [yrc_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ----- src/yrc_lane.sv -----
// One pixel lane: luma product, then chroma sums, floor shift and saturation.
`timescale 1ns / 1ps
module yrc_lane
(
    input  logic              clk,
    input  logic              take,
    input  logic [7:0]        luma,
    input  yrc_pkg::chroma_t  chroma,
    output yrc_pkg::rgb_t     rgb
);

    localparam logic signed [9:0] COEF_Y = 10'sd298;
    localparam logic signed [9:0] LUMA_BIAS = 10'sd16;
    localparam logic signed [yrc_pkg::SUM_W-1:0] ROUND_C = 20'sd128;

    logic signed [9:0]                  luma_sub;
    logic signed [yrc_pkg::PROD_W-1:0]  luma_prod;
    logic signed [yrc_pkg::PROD_W-1:0]  luma_reg;
    logic signed [yrc_pkg::SUM_W-1:0]   red_sum;
    logic signed [yrc_pkg::SUM_W-1:0]   green_sum;
    logic signed [yrc_pkg::SUM_W-1:0]   blue_sum;

    // floor(s / 256) clamped to 0..255
    function automatic logic [7:0] sat8(input logic signed [yrc_pkg::SUM_W-1:0] s);
        logic [7:0] q;
        if (s[yrc_pkg::SUM_W-1])
        begin
            q = 8'h00;
        end
        else if (|s[yrc_pkg::SUM_W-2:16])
        begin
            q = 8'hFF;
        end
        else
        begin
            q = s[15:8];
        end
        return q;
    endfunction

    assign luma_sub  = $signed({2'b00, luma}) - LUMA_BIAS;
    assign luma_prod = luma_sub * COEF_Y;

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            luma_reg <= luma_prod;
        end
    end

    assign red_sum   = luma_reg + chroma.red_v + ROUND_C;
    assign green_sum = luma_reg - chroma.green_uv + ROUND_C;
    assign blue_sum  = luma_reg + chroma.blue_u + ROUND_C;

    assign rgb.red   = sat8(red_sum);
    assign rgb.green = sat8(green_sum);
    assign rgb.blue  = sat8(blue_sum);

endmodule

// ----- src/yrc_pos.sv -----
// Registers, crop window bounds and frame position counters.
`timescale 1ns / 1ps
module yrc_pos
#(
    parameter int PIX_WIDTH_CAP  = yrc_pkg::PIX_WIDTH_CAP_DEF,
    parameter int PIX_HEIGHT_CAP = yrc_pkg::PIX_HEIGHT_CAP_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    yrc_cfg_if.sink             cfg,
    input  logic                take,
    input  logic                sof,
    output yrc_pkg::pos_info_t  info,
    output yrc_pkg::pos_ctl_t   ctl
);

    localparam int PAIR_LIM = PIX_WIDTH_CAP / 2;
    localparam int COL_W = (PAIR_LIM > 1) ? $clog2(PAIR_LIM) : 1;
    localparam int ROW_W = (PIX_HEIGHT_CAP > 1) ? $clog2(PIX_HEIGHT_CAP) : 1;
    localparam logic [yrc_pkg::CMP_W-1:0] PAIR_LIM_C   = yrc_pkg::CMP_W'(PAIR_LIM);
    localparam logic [yrc_pkg::CMP_W-1:0] HEIGHT_LIM_C = yrc_pkg::CMP_W'(PIX_HEIGHT_CAP);

    logic [11:0] cam_width_reg;
    logic [12:0] cam_height_reg;
    logic        crop_en_reg;
    logic [10:0] x_off_reg;
    logic [11:0] y_off_reg;
    logic [11:0] win_width_reg;
    logic [12:0] win_height_reg;
    logic        byte_order_reg;
    logic        busy_reg;

    logic [yrc_pkg::CMP_W-1:0] w_next, h_next, x0_next, x1_next, y0_next, y1_next;
    logic [yrc_pkg::CMP_W-1:0] x_end, y_end;
    logic [yrc_pkg::CMP_W-1:0] w_reg, h_reg, x0_reg, x1_reg, y0_reg, y1_reg;

    logic [COL_W-1:0] col_reg, col_next, col_cur;
    logic [ROW_W-1:0] row_reg, row_next, row_cur;
    logic [yrc_pkg::CMP_W-1:0] col_w, row_w, col_inc, row_inc;

    logic cfg_take;

    assign cfg.ready = 1'b1;
    assign cfg_take  = cfg.valid && cfg.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cam_width_reg  <= 12'd320;
            cam_height_reg <= 13'd480;
            crop_en_reg    <= 1'b0;
            x_off_reg      <= '0;
            y_off_reg      <= '0;
            win_width_reg  <= 12'd320;
            win_height_reg <= 13'd480;
            byte_order_reg <= 1'b0;
            busy_reg       <= 1'b1;
        end
        else
        begin
            // busy is set after a write (and after reset) while the window bounds settle
            busy_reg <= cfg_take;
            if (cfg_take)
            begin
                case (cfg.index)
                    yrc_pkg::REG_CAM_WIDTH:   cam_width_reg  <= cfg.data[11:0];
                    yrc_pkg::REG_CAM_HEIGHT:  cam_height_reg <= cfg.data[12:0];
                    yrc_pkg::REG_CROP_ENABLE: crop_en_reg    <= cfg.data[0];
                    yrc_pkg::REG_X_OFF:       x_off_reg      <= cfg.data[10:0];
                    yrc_pkg::REG_Y_OFF:       y_off_reg      <= cfg.data[11:0];
                    yrc_pkg::REG_WIN_WIDTH:   win_width_reg  <= cfg.data[11:0];
                    yrc_pkg::REG_WIN_HEIGHT:  win_height_reg <= cfg.data[12:0];
                    yrc_pkg::REG_BYTE_ORDER:  byte_order_reg <= cfg.data[0];
                    default: ;
                endcase
            end
        end
    end

    always_comb
    begin
        if (cam_width_reg == '0 || yrc_pkg::CMP_W'(cam_width_reg) > PAIR_LIM_C)
        begin
            w_next = PAIR_LIM_C;
        end
        else
        begin
            w_next = yrc_pkg::CMP_W'(cam_width_reg);
        end
        if (cam_height_reg == '0 || yrc_pkg::CMP_W'(cam_height_reg) > HEIGHT_LIM_C)
        begin
            h_next = HEIGHT_LIM_C;
        end
        else
        begin
            h_next = yrc_pkg::CMP_W'(cam_height_reg);
        end

        x_end = yrc_pkg::CMP_W'(x_off_reg) + yrc_pkg::CMP_W'(win_width_reg);
        y_end = yrc_pkg::CMP_W'(y_off_reg) + yrc_pkg::CMP_W'(win_height_reg);

        if (crop_en_reg)
        begin
            x0_next = yrc_pkg::CMP_W'(x_off_reg);
            x1_next = (x_end > w_next) ? w_next : x_end;
            y0_next = yrc_pkg::CMP_W'(y_off_reg);
            y1_next = (y_end > h_next) ? h_next : y_end;
        end
        else
        begin
            x0_next = '0;
            x1_next = w_next;
            y0_next = '0;
            y1_next = h_next;
        end
    end

    always_ff @(posedge clk)
    begin
        w_reg  <= w_next;
        h_reg  <= h_next;
        x0_reg <= x0_next;
        x1_reg <= x1_next;
        y0_reg <= y0_next;
        y1_reg <= y1_next;
    end

    assign col_cur = sof ? '0 : col_reg;
    assign row_cur = sof ? '0 : row_reg;
    assign col_w   = yrc_pkg::CMP_W'(col_cur);
    assign row_w   = yrc_pkg::CMP_W'(row_cur);
    assign col_inc = col_w + 1'b1;
    assign row_inc = row_w + 1'b1;

    assign info.emit = (col_w >= x0_reg) && (col_w < x1_reg)
                    && (row_w >= y0_reg) && (row_w < y1_reg);
    assign info.row_end   = (col_inc == x1_reg);
    assign info.frame_end = (col_inc == x1_reg) && (row_inc == y1_reg);

    always_comb
    begin
        if (col_inc >= w_reg)
        begin
            col_next = '0;
            row_next = (row_inc >= h_reg) ? '0 : row_inc[ROW_W-1:0];
        end
        else
        begin
            col_next = col_inc[COL_W-1:0];
            row_next = row_cur;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (take)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    assign ctl.byte_order = byte_order_reg;
    assign ctl.busy       = busy_reg;

endmodule

// ----- src/yuv422_to_rgb_crop.sv -----
// Top level: packed 4:2:2 macropixels in, cropped RGB888 pixel pairs out.
// One macropixel is accepted every clock while input ready is high. Two lanes convert
// the pair's pixels side by side with shared chroma products. The products are
// registered at the edge that takes the macropixel, the conversion stage then forms
// the sums, floor shift and saturation, and the merged pair is written into a
// four-beat output queue, from whose head the result is offered. Input ready depends
// only on registered state: it drops while the queue plus the beat in flight fill
// it, after each register write, and after reset while the window bounds settle.
// Macropixels outside the crop window are taken and dropped without a result.
// Horizontal offsets count pixel pairs.
`timescale 1ns / 1ps
module yuv422_to_rgb_crop
#(
    parameter int PIX_WIDTH_CAP  = yrc_pkg::PIX_WIDTH_CAP_DEF,
    parameter int PIX_HEIGHT_CAP = yrc_pkg::PIX_HEIGHT_CAP_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    yrc_pix_if.sink    pixel,
    yrc_res_if.source  result,
    yrc_cfg_if.sink    cfg
);

    localparam logic signed [10:0] COEF_RV = 11'sd409;
    localparam logic signed [10:0] COEF_GU = 11'sd100;
    localparam logic signed [10:0] COEF_GV = 11'sd208;
    localparam logic signed [10:0] COEF_BU = 11'sd516;

    yrc_pkg::pos_info_t info;
    yrc_pkg::pos_ctl_t  ctl;

    logic       take;
    logic [7:0] luma_a, luma_b, cb, cr;
    logic signed [7:0] d_u, e_v;
    yrc_pkg::chroma_t chroma_next;

    logic              s1_valid_reg;
    logic [7:0]        s1_luma_a_reg, s1_luma_b_reg;
    logic              s1_row_end_reg, s1_frame_end_reg;
    yrc_pkg::chroma_t  chroma_reg;

    yrc_pkg::rgb_t     rgb_a, rgb_b;
    yrc_pkg::result_t  entry;

    yrc_pkg::result_t  q_mem [yrc_pkg::OUT_DEPTH];
    logic [yrc_pkg::OUT_PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [yrc_pkg::OUT_CNT_W-1:0] cnt_reg, cnt_next;
    logic push, pop;
    yrc_pkg::result_t  head;

    yrc_pos #(
        .PIX_WIDTH_CAP  (PIX_WIDTH_CAP),
        .PIX_HEIGHT_CAP (PIX_HEIGHT_CAP)
    ) u_pos (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .take  (take),
        .sof   (pixel.start_of_frame),
        .info  (info),
        .ctl   (ctl)
    );

    assign pixel.ready = !ctl.busy
        && ((cnt_reg + yrc_pkg::OUT_CNT_W'(s1_valid_reg))
            < yrc_pkg::OUT_CNT_W'(yrc_pkg::OUT_DEPTH));
    assign take = pixel.valid && pixel.ready;

    always_comb
    begin
        if (ctl.byte_order)
        begin
            luma_a = pixel.byte_zero;
            cb     = pixel.byte_one;
            luma_b = pixel.byte_two;
            cr     = pixel.byte_three;
        end
        else
        begin
            cb     = pixel.byte_zero;
            luma_a = pixel.byte_one;
            cr     = pixel.byte_two;
            luma_b = pixel.byte_three;
        end
    end

    // x - 128 for an 8-bit sample is a flip of the top bit
    assign d_u = $signed({~cb[7], cb[6:0]});
    assign e_v = $signed({~cr[7], cr[6:0]});

    assign chroma_next.red_v    = e_v * COEF_RV;
    assign chroma_next.green_uv = d_u * COEF_GU + e_v * COEF_GV;
    assign chroma_next.blue_u   = d_u * COEF_BU;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= take && info.emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            s1_luma_a_reg    <= luma_a;
            s1_luma_b_reg    <= luma_b;
            s1_row_end_reg   <= info.row_end;
            s1_frame_end_reg <= info.frame_end;
            chroma_reg       <= chroma_next;
        end
    end

    yrc_lane u_lane_a (
        .clk    (clk),
        .take   (take),
        .luma   (luma_a),
        .chroma (chroma_reg),
        .rgb    (rgb_a)
    );

    yrc_lane u_lane_b (
        .clk    (clk),
        .take   (take),
        .luma   (luma_b),
        .chroma (chroma_reg),
        .rgb    (rgb_b)
    );

    // merge both lanes with the position marks into one beat
    assign entry.luma_first  = s1_luma_a_reg;
    assign entry.luma_second = s1_luma_b_reg;
    assign entry.first       = rgb_a;
    assign entry.second      = rgb_b;
    assign entry.row_end     = s1_row_end_reg;
    assign entry.frame_end   = s1_frame_end_reg;

    assign push = s1_valid_reg;
    assign pop  = result.valid && result.ready;

    always_comb
    begin
        cnt_next = cnt_reg;
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg    <= '0;
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem[wr_ptr_reg] <= entry;
        end
    end

    assign head = q_mem[rd_ptr_reg];

    assign result.valid        = (cnt_reg != '0);
    assign result.luma_first   = head.luma_first;
    assign result.luma_second  = head.luma_second;
    assign result.red_first    = head.first.red;
    assign result.green_first  = head.first.green;
    assign result.blue_first   = head.first.blue;
    assign result.red_second   = head.second.red;
    assign result.green_second = head.second.green;
    assign result.blue_second  = head.second.blue;
    assign result.row_end      = head.row_end;
    assign result.frame_end    = head.frame_end;

    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= yrc_pkg::OUT_CNT_W'(yrc_pkg::OUT_DEPTH))
        else $error("output queue overfilled");

    a_frame_end_on_row_end: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> (!result.frame_end || result.row_end))
        else $error("frame end without row end");

    a_hold_after_write: assert property (@(posedge clk) disable iff (!rst_n)
        (cfg.valid && cfg.ready) |=> !pixel.ready)
        else $error("pixel taken while window bounds settle");

    a_stage_from_take: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg |-> $past(take))
        else $error("conversion stage valid without a taken beat");

endmodule
